// File: design/isu_pkg.sv
// ----------------------------------------------------------------------------
// isu_pkg: shared types and constants of the integer set membership unit
// Item codes, field widths and hash constants used by the front, the back
// and the channel interfaces.
// ----------------------------------------------------------------------------
package isu_pkg;

  localparam int KIND_W  = 2;
  localparam int VALUE_W = 32;
  localparam int EPOCH_W = 8;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  localparam kind_t KIND_CLEAR  = 2'd0;
  localparam kind_t KIND_INSERT = 2'd1;
  localparam kind_t KIND_QUERY  = 2'd2;

  // Multiplicative hash constant (golden ratio).
  localparam value_t HASH_MULT = 32'h9E37_79B1;

  // Tag written by the sweep; live epochs never take this value.
  localparam epoch_t EPOCH_SWEPT = '0;
  localparam epoch_t EPOCH_FIRST = 8'd1;
  localparam epoch_t EPOCH_LAST  = '1;

endpackage

// File: design/isu_in_if.sv
// ----------------------------------------------------------------------------
// isu_in_if: command channel
// Carries one clear, insert or query item per valid/ready handshake.
// ----------------------------------------------------------------------------
interface isu_in_if;
  logic                                 valid;
  logic                                 ready;
  isu_pkg::kind_t                       kind;
  logic signed [isu_pkg::VALUE_W-1:0]   value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

// File: design/isu_out_if.sv
// ----------------------------------------------------------------------------
// isu_out_if: query result channel
// Carries the found bit and the sticky overflow flag of one query.
// ----------------------------------------------------------------------------
interface isu_out_if;
  logic valid;
  logic ready;
  logic found;
  logic overflowed;

  modport source (output valid, output found, output overflowed, input ready);
  modport sink   (input valid, input found, input overflowed, output ready);
endinterface

// File: design/isu_front.sv
// ----------------------------------------------------------------------------
// isu_front: command intake and home slot hashing
// Drops unused codes and computes the home slot of each value in a
// three-stage pipeline: hash multiply, fold plus reciprocal multiply,
// remainder. The final correction sits in front of the queue push.
// ----------------------------------------------------------------------------
module isu_front #(
  parameter int CAPACITY = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  isu_in_if.sink                        in_i,
  input  logic                          hold_i,
  output logic                          push_valid_o,
  input  logic                          push_ready_i,
  output isu_pkg::kind_t                push_kind_o,
  output isu_pkg::value_t               push_value_o,
  output logic [$clog2(CAPACITY)-1:0]   push_home_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam isu_pkg::value_t CAP_V = 32'(CAPACITY);
  // floor(2^32 / CAPACITY); quotient estimate is low by at most one
  localparam isu_pkg::value_t RECIP = 32'((64'd1 << 32) / CAPACITY);

  logic            en;
  logic            take;
  logic            va_q, vb_q, vc_q;
  isu_pkg::kind_t  ka_q, kb_q, kc_q;
  isu_pkg::value_t vala_q, valb_q, valc_q;
  isu_pkg::value_t ha_q;
  isu_pkg::value_t xb_q, qb_q;
  isu_pkg::value_t rc_q;
  isu_pkg::value_t ha_d, xb_d, rc_d, home_full;
  logic [63:0]     qprod;
  logic            known;

  assign en         = !vc_q || push_ready_i;
  assign in_i.ready = en && !hold_i;
  assign take       = in_i.valid && in_i.ready;
  assign known      = in_i.kind inside {isu_pkg::KIND_CLEAR, isu_pkg::KIND_INSERT,
                                        isu_pkg::KIND_QUERY};

  always_comb begin
    ha_d      = $unsigned(in_i.value) * isu_pkg::HASH_MULT;
    xb_d      = ha_q ^ {16'd0, ha_q[31:16]};
    qprod     = 64'(xb_d) * 64'(RECIP);
    rc_d      = xb_q - qb_q * CAP_V;
    home_full = (rc_q >= CAP_V) ? (rc_q - CAP_V) : rc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
    end else if (en) begin
      va_q <= take && known;
      vb_q <= va_q;
      vc_q <= vb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ka_q   <= in_i.kind;
      vala_q <= $unsigned(in_i.value);
      ha_q   <= ha_d;
      kb_q   <= ka_q;
      valb_q <= vala_q;
      xb_q   <= xb_d;
      qb_q   <= qprod[63:32];
      kc_q   <= kb_q;
      valc_q <= valb_q;
      rc_q   <= rc_d;
    end
  end

  assign push_valid_o = vc_q;
  assign push_kind_o  = kc_q;
  assign push_value_o = valc_q;
  assign push_home_o  = home_full[IDX_W-1:0];

endmodule

// File: design/isu_fifo.sv
// ----------------------------------------------------------------------------
// isu_fifo: short command queue
// Decouples the hashing front from the probing back.
// ----------------------------------------------------------------------------
module isu_fifo #(
  parameter int WIDTH = 54,
  parameter int DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: design/isu_engine.sv
// ----------------------------------------------------------------------------
// isu_engine: linear probing engine
// Walks the probe sequence through the slot memory, one slot at a time, read
// then compared. Each slot holds an epoch tag plus the value; a slot is live
// when its tag is the current epoch; a clear bumps it, retagging all on wrap.
// ----------------------------------------------------------------------------
module isu_engine #(
  parameter int CAPACITY = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          pop_valid_i,
  output logic                          pop_ready_o,
  input  isu_pkg::kind_t                pop_kind_i,
  input  isu_pkg::value_t               pop_value_i,
  input  logic [$clog2(CAPACITY)-1:0]   pop_home_i,
  output logic                          sweeping_o,
  isu_out_if.source                     out_o
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int WORD_W = isu_pkg::EPOCH_W + isu_pkg::VALUE_W;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CAPACITY - 1);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_CHECK
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  idx_q, idx_inc;
  logic [IDX_W-1:0]  n_q;
  logic [CNT_W-1:0]  count_q;
  isu_pkg::epoch_t   epoch_q;
  logic              ovf_q;
  isu_pkg::kind_t    kind_q;
  isu_pkg::value_t   val_q;
  logic              ovalid_q, ofound_q, oovf_q;

  logic [WORD_W-1:0] slots [CAPACITY];
  logic [WORD_W-1:0] rdata_q;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;

  logic slot_live, slot_hit, done, is_query, out_free, ins_write, issue;

  always_comb begin
    idx_inc   = (idx_q == IDX_LAST) ? '0 : idx_q + 1'b1;
    slot_live = rdata_q[WORD_W-1 -: isu_pkg::EPOCH_W] == epoch_q;
    slot_hit  = slot_live && (rdata_q[isu_pkg::VALUE_W-1:0] == val_q);
    done      = !slot_live || slot_hit || (n_q == IDX_LAST);
    is_query  = kind_q == isu_pkg::KIND_QUERY;
    out_free  = !ovalid_q || out_o.ready;
    issue     = (state_q == ST_CHECK) && done && is_query && out_free;
    ins_write = (state_q == ST_CHECK) && (kind_q == isu_pkg::KIND_INSERT) &&
                !slot_live && (count_q < CNT_W'(CAPACITY));
    mem_we    = (state_q == ST_SWEEP) || ins_write;
    mem_wdata = (state_q == ST_SWEEP) ? {isu_pkg::EPOCH_SWEPT, isu_pkg::VALUE_W'(0)}
                                      : {epoch_q, val_q};
  end

  assign pop_ready_o    = state_q == ST_IDLE;
  assign sweeping_o     = state_q == ST_SWEEP;
  assign out_o.valid      = ovalid_q;
  assign out_o.found      = ofound_q;
  assign out_o.overflowed = oovf_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slots[idx_q] <= mem_wdata;
    end
    rdata_q <= slots[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_SWEEP;
      idx_q    <= '0;
      n_q      <= '0;
      count_q  <= '0;
      epoch_q  <= isu_pkg::EPOCH_FIRST;
      ovf_q    <= 1'b0;
      kind_q   <= isu_pkg::KIND_CLEAR;
      val_q    <= '0;
      ovalid_q <= 1'b0;
      ofound_q <= 1'b0;
      oovf_q   <= 1'b0;
    end else begin
      if (issue) begin
        ovalid_q <= 1'b1;
      end else if (ovalid_q && out_o.ready) begin
        ovalid_q <= 1'b0;
      end
      case (state_q)
        ST_SWEEP: begin
          idx_q <= idx_inc;
          if (idx_q == IDX_LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (pop_valid_i) begin
            kind_q <= pop_kind_i;
            val_q  <= pop_value_i;
            n_q    <= '0;
            if (pop_kind_i == isu_pkg::KIND_CLEAR) begin
              count_q <= '0;
              ovf_q   <= 1'b0;
              if (epoch_q == isu_pkg::EPOCH_LAST) begin
                // epochs used up: retag every slot before reuse
                epoch_q <= isu_pkg::EPOCH_FIRST;
                idx_q   <= '0;
                state_q <= ST_SWEEP;
              end else begin
                epoch_q <= epoch_q + 1'b1;
              end
            end else begin
              idx_q   <= pop_home_i;
              state_q <= ST_READ;
            end
          end
        end
        ST_READ: begin
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (!done) begin
            idx_q   <= idx_inc;
            n_q     <= n_q + 1'b1;
            state_q <= ST_READ;
          end else if (is_query) begin
            if (out_free) begin
              ofound_q <= slot_hit;
              oovf_q   <= ovf_q;
              state_q  <= ST_IDLE;
            end
          end else begin
            if (ins_write) begin
              count_q <= count_q + 1'b1;
            end else if (!slot_hit) begin
              ovf_q <= 1'b1;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_epoch_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    epoch_q != isu_pkg::EPOCH_SWEPT)
    else $error("live epoch equals sweep tag");

  a_result_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CHECK && done && is_query && out_free) |=> ovalid_q)
    else $error("finished query gave no result");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q > $past(count_q)) |-> (count_q == $past(count_q) + 1'b1))
    else $error("entry count jumped");

endmodule

// File: design/integer_set_membership_unit.sv
// ----------------------------------------------------------------------------
// integer_set_membership_unit: hashed set of signed 32-bit integers
// Clear, insert and query items on in_i; one found/overflow item per query
// on out_o. Open addressing with linear probing over CAPACITY slots.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries kind (clear, insert, query) and value; unused kind codes
//         are dropped. out_o carries found and overflowed for each query.
//   An item passes a 3-stage hash pipeline, a QUEUE_DEPTH-entry queue and
//   the probing engine. The engine fetches an item from the queue, then
//   reads and compares each slot probed in turn; a clear is handled at
//   the fetch. A query's result is registered onto out_o once its last
//   compare is done and out_o is free. After reset the engine retags every
//   slot, one a cycle; in_i.ready stays low meanwhile. The same sweep runs
//   on every 255th clear, when the epoch tags wrap.
//   A stalled out_o holds its result; the engine finishes the next query's
//   probe and waits, while the front and queue keep taking items until
//   the queue fills.
// ----------------------------------------------------------------------------
module integer_set_membership_unit #(
  parameter int CAPACITY    = 1024,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  isu_in_if.sink     in_i,
  isu_out_if.source  out_o
);

  localparam int IDX_W   = $clog2(CAPACITY);
  localparam int ENTRY_W = isu_pkg::KIND_W + isu_pkg::VALUE_W + IDX_W;

  logic                 push_valid, push_ready, pop_valid, pop_ready, sweeping;
  isu_pkg::kind_t       push_kind;
  isu_pkg::value_t      push_value;
  logic [IDX_W-1:0]     push_home;
  logic [ENTRY_W-1:0]   push_data, pop_data;

  isu_front #(.CAPACITY(CAPACITY)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .hold_i       (sweeping),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_kind_o  (push_kind),
    .push_value_o (push_value),
    .push_home_o  (push_home)
  );

  assign push_data = {push_kind, push_value, push_home};

  isu_fifo #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  isu_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_kind_i  (pop_data[ENTRY_W-1 -: isu_pkg::KIND_W]),
    .pop_value_i (pop_data[IDX_W +: isu_pkg::VALUE_W]),
    .pop_home_i  (pop_data[IDX_W-1:0]),
    .sweeping_o  (sweeping),
    .out_o       (out_o)
  );

endmodule
